>>> rtl/multilevel_page_table_walker_macros.svh
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define MULTILEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// same-cycle implication
`define MLPTW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MLPTW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mlptw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Codes and fixed widths shared by the walker.
// ----------------------------------------------------------------------------
package mlptw_pkg;

    localparam int ADDR_BITS = 32;
    localparam int WIN_BITS  = 48;
    localparam int MAP_BITS  = 32;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_POOL_FULL = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_LEVEL_COUNT  = 3'd0;
    localparam t_cfg_index CFG_LEVEL_BITS_0 = 3'd1;
    localparam t_cfg_index CFG_LEVEL_BITS_1 = 3'd2;
    localparam t_cfg_index CFG_LEVEL_BITS_2 = 3'd3;
    localparam t_cfg_index CFG_LEVEL_BITS_3 = 3'd4;

endpackage

>>> rtl/multilevel_page_table_walker.sv
// ----------------------------------------------------------------------------
// Multilevel page table walker
// Radix tree of one to four levels in a node pool, insert and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Command: raise i_start with i_mode, i_virt_address and i_frame_number;
//   the word is taken at a rising edge where i_start is high and o_busy low.
//   Result: o_done pulses for one cycle with o_status, o_found_frame and
//   o_mapping_total; the receiver must take it in that cycle.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_index at once
//   (0 level count, 1..4 level widths); write only while idle.
//   Timing: each level walked takes an S_RD state, which issues the entry
//   memory read, and an S_EV state, which evaluates (and writes back) the
//   entry. o_done is registered from the last S_EV, and the next word can
//   be taken at the edge that ends that o_done cycle; no new word is taken
//   while a walk is in progress. A walk that misses or runs out of nodes
//   stops at that level. The registered read of the entry memory is why
//   each level needs its S_RD state.
//   Reset: the entry memory is swept to zero one entry per cycle with
//   o_busy high; config writes are still taken. The pool restarts at
//   node 1 and the count at zero.
// ----------------------------------------------------------------------------
`include "multilevel_page_table_walker_macros.svh"

module multilevel_page_table_walker #(
    parameter int NODE_POOL      = 64,
    parameter int MAX_LEVEL_BITS = 8,
    parameter int FRAME_BITS     = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_mode,
    input  logic [mlptw_pkg::ADDR_BITS-1:0] i_virt_address,
    input  logic [FRAME_BITS-1:0]           i_frame_number,
    output logic                            o_done,
    output mlptw_pkg::t_status              o_status,
    output logic [FRAME_BITS-1:0]           o_found_frame,
    output logic [mlptw_pkg::MAP_BITS-1:0]  o_mapping_total,
    input  logic                            i_cfg_we,
    input  mlptw_pkg::t_cfg_index           i_cfg_index,
    input  logic [3:0]                      i_cfg_data
);

    localparam int NB    = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
    localparam int NFW   = $clog2(NODE_POOL + 1);
    localparam int PW    = (FRAME_BITS > NB) ? FRAME_BITS : NB;
    localparam int EW    = PW + 1;
    localparam int AW    = NB + MAX_LEVEL_BITS;
    localparam int DEPTH = NODE_POOL << MAX_LEVEL_BITS;
    localparam int WIN   = mlptw_pkg::WIN_BITS;
    localparam logic [3:0] MLB4 = 4'(MAX_LEVEL_BITS);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RD, S_EV} t_state;

    t_state                         r_state, n_state;
    logic [1:0]                     r_lvl, n_lvl;
    logic [NB-1:0]                  r_node, n_node;
    logic [WIN-1:0]                 r_win, n_win;
    logic [AW-1:0]                  r_slot, n_slot;
    logic [NFW-1:0]                 r_next_free, n_next_free;
    logic [mlptw_pkg::MAP_BITS-1:0] r_map, n_map;
    logic                           r_mode, n_mode;
    logic [FRAME_BITS-1:0]          r_frame, n_frame;
    logic                           r_done, n_done;
    mlptw_pkg::t_status             r_status, n_status;
    logic [FRAME_BITS-1:0]          r_found, n_found;

    logic [2:0]                     r_level_count;
    logic [3:0]                     r_level_bits [4];

    logic [EW-1:0]                  r_mem [DEPTH];
    logic [EW-1:0]                  r_rdata;
    logic [AW-1:0]                  rd_addr;
    logic                           mem_we;
    logic [EW-1:0]                  mem_wdata;

    logic [3:0]                     cur_bits;
    logic [MAX_LEVEL_BITS-1:0]      cur_idx;
    logic [1:0]                     last_lvl;
    logic [PW-1:0]                  rd_payload;
    logic                           child_ok;

    // clamp the level width to 1..MAX_LEVEL_BITS
    function automatic logic [3:0] clamp_bits(input logic [3:0] b);
        logic [3:0] res;
        res = b;
        if (b == 4'd0) begin
            res = 4'd1;
        end else if (b > MLB4) begin
            res = MLB4;
        end
        return res;
    endfunction

    assign cur_bits = clamp_bits(r_level_bits[r_lvl]);
    assign cur_idx  = r_win[WIN-1 -: MAX_LEVEL_BITS] >> (MLB4 - cur_bits);
    assign rd_addr  = {r_node, cur_idx};

    always_comb begin
        if (r_level_count == 3'd0) begin
            last_lvl = 2'd0;
        end else if (r_level_count > 3'd4) begin
            last_lvl = 2'd3;
        end else begin
            last_lvl = 2'(r_level_count - 3'd1);
        end
    end

    assign rd_payload = r_rdata[PW-1:0];
    assign child_ok   = r_rdata[EW-1] && ({1'b0, rd_payload} < (PW + 1)'(NODE_POOL));

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_found_frame   = r_found;
    assign o_mapping_total = r_map;

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_node      = r_node;
        n_win       = r_win;
        n_slot      = r_slot;
        n_next_free = r_next_free;
        n_map       = r_map;
        n_mode      = r_mode;
        n_frame     = r_frame;
        n_done      = 1'b0;
        n_status    = r_status;
        n_found     = r_found;
        mem_we      = 1'b0;
        mem_wdata   = '0;

        unique case (r_state)
            S_CLEAR: begin
                // r_slot doubles as the sweep address
                mem_we = 1'b1;
                n_slot = r_slot + 1'b1;
                if (r_slot == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_mode  = i_mode;
                    n_frame = i_frame_number;
                    n_win   = {i_virt_address, (WIN - mlptw_pkg::ADDR_BITS)'(0)};
                    n_lvl   = 2'd0;
                    n_node  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_slot  = rd_addr;
                n_win   = r_win << cur_bits;
                n_state = S_EV;
            end
            S_EV: begin
                if (r_lvl == last_lvl) begin
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                    n_found  = '0;
                    n_status = mlptw_pkg::ST_OK;
                    if (r_mode == mlptw_pkg::MODE_INSERT) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, PW'(r_frame)};
                        if (r_map != '1) begin
                            n_map = r_map + 1'b1;
                        end
                    end else if (r_rdata[EW-1]) begin
                        n_found = rd_payload[FRAME_BITS-1:0];
                    end else begin
                        n_status = mlptw_pkg::ST_NOT_FOUND;
                    end
                end else if (child_ok) begin
                    n_node  = rd_payload[NB-1:0];
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_RD;
                end else if (r_mode == mlptw_pkg::MODE_LOOKUP) begin
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                    n_found  = '0;
                    n_status = mlptw_pkg::ST_NOT_FOUND;
                end else if (r_next_free >= NFW'(NODE_POOL)) begin
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                    n_found  = '0;
                    n_status = mlptw_pkg::ST_POOL_FULL;
                end else begin
                    // link a fresh node and descend into it
                    mem_we      = 1'b1;
                    mem_wdata   = {1'b1, PW'(r_next_free[NB-1:0])};
                    n_node      = r_next_free[NB-1:0];
                    n_next_free = r_next_free + 1'b1;
                    n_lvl       = r_lvl + 1'b1;
                    n_state     = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_next_free <= NFW'(1);
            r_map       <= '0;
            r_done      <= 1'b0;
            r_lvl       <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_next_free <= n_next_free;
            r_map       <= n_map;
            r_done      <= n_done;
            r_lvl       <= n_lvl;
        end
        r_node   <= n_node;
        r_win    <= n_win;
        r_mode   <= n_mode;
        r_frame  <= n_frame;
        r_status <= n_status;
        r_found  <= n_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count   <= 3'd2;
            r_level_bits[0] <= 4'd8;
            r_level_bits[1] <= 4'd8;
            r_level_bits[2] <= 4'd8;
            r_level_bits[3] <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                mlptw_pkg::CFG_LEVEL_COUNT: begin
                    r_level_count <= i_cfg_data[2:0];
                end
                mlptw_pkg::CFG_LEVEL_BITS_0, mlptw_pkg::CFG_LEVEL_BITS_1,
                mlptw_pkg::CFG_LEVEL_BITS_2, mlptw_pkg::CFG_LEVEL_BITS_3: begin
                    r_level_bits[2'(i_cfg_index - mlptw_pkg::CFG_LEVEL_BITS_0)] <= i_cfg_data;
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    `MLPTW_ASSERT_IMP(a_done_after_eval, r_done, $past(r_state) == S_EV,
        "result strobe without an evaluate cycle")
    `MLPTW_ASSERT_IMP(a_free_bound, 1'b1, r_next_free <= NFW'(NODE_POOL),
        "free node counter past the pool")
    `MLPTW_ASSERT_IMP(a_full_pool, r_done && r_status == mlptw_pkg::ST_POOL_FULL,
        r_next_free == NFW'(NODE_POOL) && r_mode == mlptw_pkg::MODE_INSERT,
        "pool_full while nodes remain")
    `MLPTW_ASSERT_IMP(a_nf_lookup, r_done && r_status == mlptw_pkg::ST_NOT_FOUND,
        r_mode == mlptw_pkg::MODE_LOOKUP, "not_found on an insert")
    `MLPTW_ASSERT_NXT(a_accept_walks, i_start && r_state == S_IDLE, r_state == S_RD,
        "accepted word did not start a walk")

endmodule

>>> verif/multilevel_page_table_walker_tb.sv
// ----------------------------------------------------------------------------
// Multilevel page table walker testbench
// Feeds insert and lookup words through the command port and checks every
// result word against a fixed expected value or a cycle-free model of the
// radix tree. A short table covers stale entries, out-of-range settings
// and pool exhaustion, then random phases run under changing tree layouts.
// ----------------------------------------------------------------------------
module multilevel_page_table_walker_tb;

    localparam int POOL_NODES    = 64;
    localparam int SLOT_BITS     = 8;
    localparam int FRAME_W       = 20;
    localparam int STORE_DEPTH   = POOL_NODES << SLOT_BITS;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 150;

    typedef struct {
        mlptw_pkg::t_status status;
        logic [FRAME_W-1:0] frame;
        logic [31:0]        total;
    } t_walk_result;

    typedef struct {
        bit                    is_cfg;
        mlptw_pkg::t_cfg_index reg_idx;
        logic [3:0]            reg_val;
        logic                  mode;
        logic [31:0]           va;
        logic [FRAME_W-1:0]    fr;
        int                    reps;
        logic [31:0]           stride;
        bit                    typed;
        t_walk_result          known;
    } t_walk_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic                  i_mode;
    logic [31:0]           i_virt_address;
    logic [FRAME_W-1:0]    i_frame_number;
    logic                  o_done;
    mlptw_pkg::t_status    o_status;
    logic [FRAME_W-1:0]    o_found_frame;
    logic [31:0]           o_mapping_total;
    logic                  i_cfg_we;
    mlptw_pkg::t_cfg_index i_cfg_index;
    logic [3:0]            i_cfg_data;

    // model of the tree: valid bit over a 20-bit child number or frame
    logic [FRAME_W:0]    page_entries [STORE_DEPTH];
    int                  free_node;
    logic [31:0]         leaf_count;
    logic [2:0]          level_count_reg;
    logic [3:0]          level_bits_reg [4];

    t_walk_result        expected_walks [$];
    t_walk_result        head;
    t_walk_row           dir_rows [$];
    logic [31:0]         seen_addrs [$];
    bit                  no_idle;
    int                  fail_count;
    int                  cycle_count;

    multilevel_page_table_walker #(
        .NODE_POOL      (POOL_NODES),
        .MAX_LEVEL_BITS (SLOT_BITS),
        .FRAME_BITS     (FRAME_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_mode          (i_mode),
        .i_virt_address  (i_virt_address),
        .i_frame_number  (i_frame_number),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_found_frame   (o_found_frame),
        .o_mapping_total (o_mapping_total),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Walk the model tree for one word; updates the store, pool and count.
    function automatic void walk_table(input logic mode, input logic [31:0] va,
                                       input logic [FRAME_W-1:0] fr,
                                       output mlptw_pkg::t_status st,
                                       output logic [FRAME_W-1:0] ff);
        int                 levels;
        int                 node;
        int                 end_bit;
        int                 width;
        int                 idx;
        int                 slot;
        logic [47:0]        wide;
        logic [FRAME_W:0]   ent;
        logic [FRAME_W-1:0] child;
        bit                 present;
        levels = (level_count_reg == 0) ? 1 : (level_count_reg > 4) ? 4 : level_count_reg;
        wide = {va, 16'h0000};
        node = 0;
        end_bit = 0;
        st = mlptw_pkg::ST_OK;
        ff = '0;
        for (int lvl = 0; lvl < levels; lvl++) begin
            width = (level_bits_reg[lvl] == 0) ? 1 :
                    (level_bits_reg[lvl] > SLOT_BITS) ? SLOT_BITS : level_bits_reg[lvl];
            end_bit += width;
            idx = int'((wide >> (48 - end_bit)) & ((48'd1 << width) - 48'd1));
            slot = node * (1 << SLOT_BITS) + idx;
            ent = page_entries[slot];
            if (lvl == levels - 1) begin
                if (mode == mlptw_pkg::MODE_INSERT) begin
                    page_entries[slot] = {1'b1, fr};
                    if (leaf_count != 32'hFFFF_FFFF) leaf_count++;
                end else if (ent[FRAME_W]) begin
                    ff = ent[FRAME_W-1:0];
                end else begin
                    st = mlptw_pkg::ST_NOT_FOUND;
                end
                break;
            end
            child = ent[FRAME_W-1:0];
            // a leftover frame too large for a node number counts as absent
            present = ent[FRAME_W] && (child < POOL_NODES);
            if (!present) begin
                if (mode == mlptw_pkg::MODE_LOOKUP) begin
                    st = mlptw_pkg::ST_NOT_FOUND;
                    break;
                end
                if (free_node >= POOL_NODES) begin
                    st = mlptw_pkg::ST_POOL_FULL;
                    break;
                end
                child = free_node[FRAME_W-1:0];
                free_node++;
                page_entries[slot] = {1'b1, child};
            end
            node = int'(child);
        end
    endfunction

    function automatic t_walk_row cfg_row(input mlptw_pkg::t_cfg_index idx,
                                          input logic [3:0] val);
        t_walk_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_walk_row cmd_row(input logic mode, input logic [31:0] va,
                                          input logic [FRAME_W-1:0] fr, input int reps,
                                          input logic [31:0] stride);
        t_walk_row r;
        r = '{default: '0};
        r.mode = mode;
        r.va = va;
        r.fr = fr;
        r.reps = reps;
        r.stride = stride;
        return r;
    endfunction

    function automatic t_walk_row known_row(input logic mode, input logic [31:0] va,
                                            input logic [FRAME_W-1:0] fr,
                                            input mlptw_pkg::t_status st,
                                            input logic [FRAME_W-1:0] ff,
                                            input logic [31:0] tot);
        t_walk_row r;
        r = cmd_row(mode, va, fr, 1, 32'h0);
        r.typed = 1'b1;
        r.known.status = st;
        r.known.frame = ff;
        r.known.total = tot;
        return r;
    endfunction

    function automatic void add_row(input t_walk_row r);
        dir_rows = {dir_rows, r};
    endfunction

    // Present one word after a random gap, hold it until taken, then predict.
    task automatic issue_word(input logic mode, input logic [31:0] va,
                              input logic [FRAME_W-1:0] fr, input bit typed,
                              input t_walk_result known);
        int           gap;
        t_walk_result got;
        t_walk_result want;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
        @(negedge i_clk);
        i_start = 1'b1;
        i_mode = mode;
        i_virt_address = va;
        i_frame_number = fr;
        do @(posedge i_clk); while (o_busy);
        walk_table(mode, va, fr, got.status, got.frame);
        got.total = leaf_count;
        if (typed) begin
            want = known;
        end else begin
            want = got;
        end
        expected_walks = {expected_walks, want};
        seen_addrs = {seen_addrs, va};
        if (seen_addrs.size() > 48) void'(seen_addrs.pop_front());
    endtask

    // Drop start and wait until every result word is in and the block is free.
    task automatic settle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (expected_walks.size() != 0 || o_busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input mlptw_pkg::t_cfg_index idx, input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        if (idx == mlptw_pkg::CFG_LEVEL_COUNT) level_count_reg = val[2:0];
        else level_bits_reg[2'(idx - mlptw_pkg::CFG_LEVEL_BITS_0)] = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (expected_walks.size() == 0) begin
                $error("result word with none expected");
                fail_count++;
            end else begin
                head = expected_walks.pop_front();
                if (o_status !== head.status) begin
                    $error("status: expected %0d, got %0d", head.status, o_status);
                    fail_count++;
                end
                if (o_found_frame !== head.frame) begin
                    $error("found_frame: expected %h, got %h", head.frame, o_found_frame);
                    fail_count++;
                end
                if (o_mapping_total !== head.total) begin
                    $error("mapping_total: expected %0d, got %0d", head.total,
                           o_mapping_total);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_walk_row          row;
        t_walk_result       none;
        logic               mode;
        logic [31:0]        va;
        logic [FRAME_W-1:0] fr;
        int                 sel;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_mode = mlptw_pkg::MODE_INSERT;
        i_virt_address = '0;
        i_frame_number = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = mlptw_pkg::CFG_LEVEL_COUNT;
        i_cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        none = '{default: '0};
        foreach (page_entries[k]) page_entries[k] = '0;
        free_node = 1;
        leaf_count = '0;
        level_count_reg = 3'd2;
        foreach (level_bits_reg[k]) level_bits_reg[k] = 4'd8;

        // default layout: two levels of 8 bits
        add_row(known_row(mlptw_pkg::MODE_LOOKUP, 32'h0000_0000, 20'h0,
                          mlptw_pkg::ST_NOT_FOUND, 20'h0, 32'd0));
        add_row(known_row(mlptw_pkg::MODE_INSERT, 32'hFFFF_FFFF, 20'hFFFFF,
                          mlptw_pkg::ST_OK, 20'h0, 32'd1));
        add_row(known_row(mlptw_pkg::MODE_LOOKUP, 32'hFFFF_0000, 20'h0,
                          mlptw_pkg::ST_OK, 20'hFFFFF, 32'd1));
        add_row(known_row(mlptw_pkg::MODE_INSERT, 32'h0000_0000, 20'h0,
                          mlptw_pkg::ST_OK, 20'h0, 32'd2));
        add_row(known_row(mlptw_pkg::MODE_INSERT, 32'hFFFF_FFFF, 20'h12345,
                          mlptw_pkg::ST_OK, 20'h0, 32'd3));
        add_row(known_row(mlptw_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF,
                          mlptw_pkg::ST_OK, 20'h12345, 32'd3));
        // zero levels acts as one: the old child pointer reads as a frame
        add_row(cfg_row(mlptw_pkg::CFG_LEVEL_COUNT, 4'd0));
        add_row(known_row(mlptw_pkg::MODE_LOOKUP, 32'hFF00_0000, 20'h0,
                          mlptw_pkg::ST_OK, 20'h1, 32'd3));
        add_row(known_row(mlptw_pkg::MODE_INSERT, 32'hAB00_0000, 20'hFFFFF,
                          mlptw_pkg::ST_OK, 20'h0, 32'd4));
        // beyond four levels acts as four: the big frame is no node number
        add_row(cfg_row(mlptw_pkg::CFG_LEVEL_COUNT, 4'd15));
        add_row(known_row(mlptw_pkg::MODE_LOOKUP, 32'hAB00_0000, 20'h0,
                          mlptw_pkg::ST_NOT_FOUND, 20'h0, 32'd4));
        add_row(cmd_row(mlptw_pkg::MODE_INSERT, 32'hAB00_0000, 20'($urandom()), 1, 32'h0));
        add_row(cfg_row(mlptw_pkg::CFG_LEVEL_BITS_0, 4'd0));
        add_row(cfg_row(mlptw_pkg::CFG_LEVEL_BITS_1, 4'd15));
        add_row(cmd_row(mlptw_pkg::MODE_INSERT, 32'h8000_0000, 20'($urandom()), 1, 32'h0));
        add_row(cmd_row(mlptw_pkg::MODE_LOOKUP, 32'h8000_0000, 20'h0, 1, 32'h0));
        // use up the node pool, then hit the wall
        add_row(cfg_row(mlptw_pkg::CFG_LEVEL_BITS_0, 4'd8));
        add_row(cmd_row(mlptw_pkg::MODE_INSERT, 32'h2000_0000, 20'($urandom()), 22,
                        32'h0100_0000));
        add_row(cmd_row(mlptw_pkg::MODE_INSERT, 32'hE000_0000, 20'($urandom()), 1, 32'h0));
        add_row(cmd_row(mlptw_pkg::MODE_LOOKUP, 32'h2000_0000, 20'h0, 4, 32'h0500_0000));
        add_row(cfg_row(mlptw_pkg::CFG_LEVEL_BITS_2, 4'd1));
        add_row(cfg_row(mlptw_pkg::CFG_LEVEL_BITS_3, 4'd1));
        add_row(cmd_row(mlptw_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF, 1, 32'h0));
        add_row(cmd_row(mlptw_pkg::MODE_INSERT, 32'h0000_0000, 20'h0, 1, 32'h0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        settle();

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.is_cfg) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                for (int k = 0; k < row.reps; k++) begin
                    issue_word(row.mode, row.va + k * row.stride, row.fr + FRAME_W'(k),
                               row.typed, row.known);
                end
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            // full size, smallest, below range, above range, then anything
            case (phase)
                0: begin
                    write_reg(mlptw_pkg::CFG_LEVEL_COUNT, 4'd4);
                    for (int k = 0; k < 4; k++) begin
                        write_reg(mlptw_pkg::t_cfg_index'(mlptw_pkg::CFG_LEVEL_BITS_0 + k),
                                  4'd8);
                    end
                end
                1: begin
                    write_reg(mlptw_pkg::CFG_LEVEL_COUNT, 4'd1);
                    for (int k = 0; k < 4; k++) begin
                        write_reg(mlptw_pkg::t_cfg_index'(mlptw_pkg::CFG_LEVEL_BITS_0 + k),
                                  4'd1);
                    end
                end
                2: begin
                    write_reg(mlptw_pkg::CFG_LEVEL_COUNT, 4'd0);
                    for (int k = 0; k < 4; k++) begin
                        write_reg(mlptw_pkg::t_cfg_index'(mlptw_pkg::CFG_LEVEL_BITS_0 + k),
                                  4'd0);
                    end
                end
                3: begin
                    write_reg(mlptw_pkg::CFG_LEVEL_COUNT, 4'd15);
                    for (int k = 0; k < 4; k++) begin
                        write_reg(mlptw_pkg::t_cfg_index'(mlptw_pkg::CFG_LEVEL_BITS_0 + k),
                                  4'd15);
                    end
                end
                default: begin
                    write_reg(mlptw_pkg::CFG_LEVEL_COUNT, 4'($urandom_range(0, 15)));
                    for (int k = 0; k < 4; k++) begin
                        write_reg(mlptw_pkg::t_cfg_index'(mlptw_pkg::CFG_LEVEL_BITS_0 + k),
                                  4'($urandom_range(0, 15)));
                    end
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
                mode = $urandom_range(0, 1) ? mlptw_pkg::MODE_LOOKUP : mlptw_pkg::MODE_INSERT;
                // mostly revisit known paths so walks reach the leaves
                sel = $urandom_range(0, 99);
                if (seen_addrs.size() > 0 && sel < 45) begin
                    va = seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
                end else if (seen_addrs.size() > 0 && sel < 70) begin
                    va = seen_addrs[$urandom_range(0, seen_addrs.size() - 1)] ^
                         ($urandom() >> $urandom_range(4, 31));
                end else begin
                    va = $urandom();
                end
                sel = $urandom_range(0, 9);
                fr = (sel == 0) ? '0 : (sel == 1) ? '1 : FRAME_W'($urandom());
                issue_word(mode, va, fr, 1'b0, none);
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/mlptw_pkg.sv
rtl/multilevel_page_table_walker.sv
verif/multilevel_page_table_walker_tb.sv
